[rtl/core/spi_nor_pkg.sv]
`timescale 1ns / 1ps

package spi_nor_pkg;

  // Default flash page size in bytes.
  localparam int unsigned PageBytesDefault = 256;

  // Flash command opcodes.
  localparam logic [7:0] CmdReadId      = 8'h9F;
  localparam logic [7:0] CmdWriteEnable = 8'h06;
  localparam logic [7:0] CmdReadStatus  = 8'h05;
  localparam logic [7:0] CmdSectorErase = 8'h20;
  localparam logic [7:0] CmdPageProgram = 8'h02;
  localparam logic [7:0] CmdReadData    = 8'h03;

  // Position of the write-in-progress flag in the status byte.
  localparam int unsigned StatusBusyBit = 0;

  // Number of bytes in the device id.
  localparam logic [15:0] IdBytes = 16'd3;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_SUPPLY = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_READ_ID = 2'd0,
    OP_ERASE   = 2'd1,
    OP_PROGRAM = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_WREN      = 4'd1,
    PH_WREN_END  = 4'd2,
    PH_CMD       = 4'd3,
    PH_A2        = 4'd4,
    PH_A1        = 4'd5,
    PH_A0        = 4'd6,
    PH_DATA      = 4'd7,
    PH_CMD_END   = 4'd8,
    PH_POLL_CMD  = 4'd9,
    PH_POLL_READ = 4'd10,
    PH_DONE_END  = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_ID   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BUSY      = 2'd1,
    STAT_NO_SUPPLY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  operation;
    logic [23:0] address;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        miso_bit;
  } req_item_t;

  typedef struct packed {
    logic        chip_select_n;
    logic        serial_clock;
    logic        serial_out;
    logic [23:0] data_out;
    logic [1:0]  data_kind;
    logic        need_byte;
    logic        busy_res;
    logic        finished;
    logic [1:0]  status;
  } res_item_t;

  // Sequencer state, all of it set to SeqStateReset by reset.
  typedef struct packed {
    phase_e      phase;
    op_e         operation;
    logic [2:0]  bit_index;
    logic        clock_high_half;
    logic [7:0]  tx_shift;
    logic [7:0]  rx_shift;
    logic [15:0] bytes_remaining;
    logic [23:0] target_address;
    logic [23:0] id_accum;
    logic        held_valid;
    logic        select_active;
    logic        pin_sclk;
    logic        pin_mosi;
  } seq_state_t;

  localparam seq_state_t SeqStateReset = '{
    phase:           PH_IDLE,
    operation:       OP_READ_ID,
    bit_index:       3'd7,
    clock_high_half: 1'b0,
    tx_shift:        8'd0,
    rx_shift:        8'd0,
    bytes_remaining: 16'd0,
    target_address:  24'd0,
    id_accum:        24'd0,
    held_valid:      1'b0,
    select_active:   1'b0,
    pin_sclk:        1'b0,
    pin_mosi:        1'b0
  };

  // True at the low half that opens a program data byte.
  function automatic logic at_program_byte_start(input seq_state_t s);
    return (s.phase == PH_DATA) && (s.operation == OP_PROGRAM) &&
           !s.clock_high_half && (s.bit_index == 3'd7);
  endfunction

  function automatic logic is_byte_phase(input phase_e p);
    return (p == PH_WREN) || ((p >= PH_CMD) && (p <= PH_DATA)) ||
           (p == PH_POLL_CMD) || (p == PH_POLL_READ);
  endfunction

endpackage

[rtl/core/spi_nor_if.sv]
`timescale 1ns / 1ps

interface spi_nor_req_if;
  logic                   valid;
  logic                   ready;
  spi_nor_pkg::req_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface spi_nor_res_if;
  logic                   valid;
  logic                   ready;
  spi_nor_pkg::res_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

[rtl/core/spi_nor_flash_command_sequencer.sv]
`timescale 1ns / 1ps

// Channel   Dir   Payload      Meaning
// req_i     in    req_item_t   start, half-period tick or program data byte
// res_o     out   res_item_t   pin levels, received data, flags, one per request
//
// Each request is handled at the edge that accepts it: the sequencer state
// and the result register both update there, so one request per cycle is
// sustained while res_o does not stall; its result is offered on the next cycle.
// A request is taken whenever the result register is empty or its result
// leaves in the same cycle; req_i stalls only while res_o stalls.
// Reset puts the sequencer in idle with chip select high.

module spi_nor_flash_command_sequencer #(
  parameter int unsigned PAGE_BYTES = spi_nor_pkg::PageBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  spi_nor_req_if.sink          req_i,
  spi_nor_res_if.source        res_o
);

  spi_nor_pkg::seq_state_t state_q, state_d;
  logic [7:0]              held_q, held_d;
  spi_nor_pkg::res_item_t  res_q, res_d;
  logic                    res_valid_q;
  logic                    accept;

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  spi_nor_step #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_step (
    .state_i    (state_q),
    .held_byte_i(held_q),
    .item_i     (req_i.item),
    .state_o    (state_d),
    .held_byte_o(held_d),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spi_nor_pkg::SeqStateReset;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // The held byte is only read while its valid flag is set.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
      res_q  <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.item  = res_q;

endmodule

[rtl/core/spi_nor_step.sv]
`timescale 1ns / 1ps

// Next-state and result logic for one request.
module spi_nor_step #(
  parameter int unsigned PAGE_BYTES = spi_nor_pkg::PageBytesDefault
) (
  input  spi_nor_pkg::seq_state_t state_i,
  input  logic [7:0]              held_byte_i,
  input  spi_nor_pkg::req_item_t  item_i,
  output spi_nor_pkg::seq_state_t state_o,
  output logic [7:0]              held_byte_o,
  output spi_nor_pkg::res_item_t  result_o
);

  localparam logic [15:0] PageLimit = 16'(PAGE_BYTES);

  spi_nor_pkg::seq_state_t s_d;
  logic [7:0]              held_d;
  logic [23:0]             data;
  spi_nor_pkg::kind_e      kind;
  spi_nor_pkg::status_e    status;
  logic                    fin;
  logic                    at_pbs;
  logic [15:0]             unloaded;
  logic                    in_prog;
  logic [7:0]              rx_new;
  logic [15:0]             rem_new;
  logic [23:0]             id_new;

  assign at_pbs = spi_nor_pkg::at_program_byte_start(state_i);

  always_comb begin
    s_d      = state_i;
    held_d   = held_byte_i;
    data     = '0;
    kind     = spi_nor_pkg::KIND_NONE;
    status   = spi_nor_pkg::STAT_OK;
    fin      = 1'b0;
    unloaded = state_i.bytes_remaining;
    in_prog  = 1'b0;
    rx_new   = {state_i.rx_shift[6:0], item_i.miso_bit};
    rem_new  = state_i.bytes_remaining - 16'd1;
    id_new   = {state_i.id_accum[15:0], rx_new};

    unique case (spi_nor_pkg::mode_e'(item_i.mode))
      spi_nor_pkg::MODE_START: begin
        if (state_i.phase != spi_nor_pkg::PH_IDLE) begin
          status = spi_nor_pkg::STAT_BUSY;
        end else begin
          s_d.operation       = spi_nor_pkg::op_e'(item_i.operation);
          s_d.target_address  = item_i.address;
          s_d.held_valid      = 1'b0;
          s_d.bit_index       = 3'd7;
          s_d.clock_high_half = 1'b0;
          unique case (spi_nor_pkg::op_e'(item_i.operation))
            spi_nor_pkg::OP_READ_ID: begin
              s_d.bytes_remaining = '0;
              s_d.phase           = spi_nor_pkg::PH_CMD;
              s_d.tx_shift        = spi_nor_pkg::CmdReadId;
            end
            spi_nor_pkg::OP_READ: begin
              s_d.bytes_remaining = item_i.byte_count;
              s_d.phase           = spi_nor_pkg::PH_CMD;
              s_d.tx_shift        = spi_nor_pkg::CmdReadData;
            end
            spi_nor_pkg::OP_PROGRAM: begin
              s_d.bytes_remaining = (item_i.byte_count > PageLimit) ?
                                    PageLimit : item_i.byte_count;
              s_d.phase           = spi_nor_pkg::PH_WREN;
              s_d.tx_shift        = spi_nor_pkg::CmdWriteEnable;
            end
            default: begin
              s_d.bytes_remaining = '0;
              s_d.phase           = spi_nor_pkg::PH_WREN;
              s_d.tx_shift        = spi_nor_pkg::CmdWriteEnable;
            end
          endcase
        end
      end

      spi_nor_pkg::MODE_SUPPLY: begin
        in_prog = (state_i.operation == spi_nor_pkg::OP_PROGRAM) &&
                  (state_i.phase != spi_nor_pkg::PH_IDLE) &&
                  (state_i.phase <= spi_nor_pkg::PH_DATA);
        // Mid-byte, the byte on the wire is already counted as loaded.
        if ((state_i.phase == spi_nor_pkg::PH_DATA) && !at_pbs &&
            (state_i.bytes_remaining != 16'd0)) begin
          unloaded = rem_new;
        end
        if (in_prog && !state_i.held_valid && (unloaded != 16'd0)) begin
          held_d         = item_i.write_byte;
          s_d.held_valid = 1'b1;
        end else begin
          status = spi_nor_pkg::STAT_NO_SUPPLY;
        end
      end

      spi_nor_pkg::MODE_TICK: begin
        if (spi_nor_pkg::is_byte_phase(state_i.phase)) begin
          if (!state_i.clock_high_half) begin
            if (at_pbs && !state_i.held_valid) begin
              // Waiting for program data: hold everything, SCLK stays low.
              s_d.pin_sclk = 1'b0;
            end else begin
              if (at_pbs) begin
                s_d.tx_shift   = held_byte_i;
                s_d.held_valid = 1'b0;
              end
              s_d.select_active   = 1'b1;
              s_d.pin_sclk        = 1'b0;
              s_d.pin_mosi        = s_d.tx_shift[state_i.bit_index];
              s_d.clock_high_half = 1'b1;
            end
          end else begin
            s_d.pin_sclk        = 1'b1;
            s_d.rx_shift        = rx_new;
            s_d.clock_high_half = 1'b0;
            if (state_i.bit_index != 3'd0) begin
              s_d.bit_index = state_i.bit_index - 3'd1;
            end else begin
              s_d.bit_index = 3'd7;
              unique case (state_i.phase)
                spi_nor_pkg::PH_WREN: begin
                  s_d.phase = spi_nor_pkg::PH_WREN_END;
                end
                spi_nor_pkg::PH_CMD: begin
                  if (state_i.operation == spi_nor_pkg::OP_READ_ID) begin
                    s_d.phase           = spi_nor_pkg::PH_DATA;
                    s_d.bytes_remaining = spi_nor_pkg::IdBytes;
                    s_d.id_accum        = '0;
                    s_d.tx_shift        = '0;
                  end else begin
                    s_d.phase    = spi_nor_pkg::PH_A2;
                    s_d.tx_shift = state_i.target_address[23:16];
                  end
                end
                spi_nor_pkg::PH_A2: begin
                  s_d.phase    = spi_nor_pkg::PH_A1;
                  s_d.tx_shift = state_i.target_address[15:8];
                end
                spi_nor_pkg::PH_A1: begin
                  s_d.phase    = spi_nor_pkg::PH_A0;
                  s_d.tx_shift = state_i.target_address[7:0];
                end
                spi_nor_pkg::PH_A0: begin
                  s_d.tx_shift = '0;
                  s_d.phase    = (state_i.bytes_remaining == 16'd0) ?
                                 spi_nor_pkg::PH_CMD_END : spi_nor_pkg::PH_DATA;
                end
                spi_nor_pkg::PH_DATA: begin
                  if (state_i.operation == spi_nor_pkg::OP_READ_ID) begin
                    s_d.id_accum = id_new;
                  end else if (state_i.operation == spi_nor_pkg::OP_READ) begin
                    data = {16'd0, rx_new};
                    kind = spi_nor_pkg::KIND_BYTE;
                  end
                  s_d.bytes_remaining = rem_new;
                  if (rem_new == 16'd0) begin
                    if (state_i.operation == spi_nor_pkg::OP_READ_ID) begin
                      data = id_new;
                      kind = spi_nor_pkg::KIND_ID;
                    end
                    s_d.phase = spi_nor_pkg::PH_CMD_END;
                  end
                end
                spi_nor_pkg::PH_POLL_CMD: begin
                  s_d.phase    = spi_nor_pkg::PH_POLL_READ;
                  s_d.tx_shift = '0;
                end
                default: begin
                  // Status poll: done once the write-in-progress flag clears.
                  if (!rx_new[spi_nor_pkg::StatusBusyBit]) begin
                    s_d.phase = spi_nor_pkg::PH_DONE_END;
                  end
                end
              endcase
            end
          end
        end else if (state_i.phase == spi_nor_pkg::PH_WREN_END) begin
          s_d.select_active = 1'b0;
          s_d.pin_sclk      = 1'b0;
          s_d.pin_mosi      = 1'b0;
          s_d.phase         = spi_nor_pkg::PH_CMD;
          s_d.tx_shift      = (state_i.operation == spi_nor_pkg::OP_ERASE) ?
                              spi_nor_pkg::CmdSectorErase :
                              spi_nor_pkg::CmdPageProgram;
        end else if (state_i.phase == spi_nor_pkg::PH_CMD_END) begin
          s_d.select_active = 1'b0;
          s_d.pin_sclk      = 1'b0;
          s_d.pin_mosi      = 1'b0;
          if ((state_i.operation == spi_nor_pkg::OP_ERASE) ||
              (state_i.operation == spi_nor_pkg::OP_PROGRAM)) begin
            s_d.phase    = spi_nor_pkg::PH_POLL_CMD;
            s_d.tx_shift = spi_nor_pkg::CmdReadStatus;
          end else begin
            s_d.phase = spi_nor_pkg::PH_IDLE;
            fin       = 1'b1;
          end
        end else if (state_i.phase == spi_nor_pkg::PH_DONE_END) begin
          s_d.select_active = 1'b0;
          s_d.pin_sclk      = 1'b0;
          s_d.pin_mosi      = 1'b0;
          s_d.phase         = spi_nor_pkg::PH_IDLE;
          fin               = 1'b1;
        end
      end

      default: begin
        // Unused mode code: no change.
      end
    endcase
  end

  assign state_o     = s_d;
  assign held_byte_o = held_d;

  always_comb begin
    result_o.chip_select_n = !s_d.select_active;
    result_o.serial_clock  = s_d.pin_sclk;
    result_o.serial_out    = s_d.pin_mosi;
    result_o.data_out      = data;
    result_o.data_kind     = kind;
    result_o.need_byte     = spi_nor_pkg::at_program_byte_start(s_d) && !s_d.held_valid;
    result_o.busy_res      = (s_d.phase != spi_nor_pkg::PH_IDLE);
    result_o.finished      = fin;
    result_o.status        = status;
  end

endmodule

[tb/spi_nor_flash_command_sequencer_tb.sv]
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer_tb;
  import spi_nor_pkg::*;

  localparam int unsigned PageBytes      = PageBytesDefault;
  localparam logic [1:0]  ModeReserved   = 2'd3;
  localparam int unsigned QuietLimit     = 5000;
  localparam int unsigned TargetRequests = 1000;
  localparam int unsigned HoldOffCycles  = 300;

  // Tracks the sequencer state request by request and queues the pin levels
  // and flags that each request should produce.
  class pin_scoreboard;
    res_item_t   expected_pins[$];
    int unsigned errors, checked, ops_done, bytes_read, ids_read;
    int unsigned busy_starts, refused_bytes, stall_ticks;

    phase_e      phase;
    op_e         op;
    bit [2:0]    bit_idx;
    bit          high_half;
    bit [7:0]    tx_byte, rx_byte, held_byte;
    bit [15:0]   remaining;
    bit [23:0]   addr, id_acc;
    bit          held_ok, cs_active, sclk, mosi;

    function new();
      phase     = PH_IDLE;
      op        = OP_READ_ID;
      bit_idx   = 3'd7;
      high_half = 1'b0;
      tx_byte   = '0;
      rx_byte   = '0;
      held_byte = '0;
      remaining = '0;
      addr      = '0;
      id_acc    = '0;
      held_ok   = 1'b0;
      cs_active = 1'b0;
      sclk      = 1'b0;
      mosi      = 1'b0;
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function bit in_status_read();
      return phase == PH_POLL_READ;
    endfunction

    function bit byte_start();
      return phase == PH_DATA && op == OP_PROGRAM && !high_half && bit_idx == 3'd7;
    endfunction

    function bit wants_byte();
      return byte_start() && !held_ok;
    endfunction

    // A data byte is taken only while part of the page is still unloaded.
    function bit byte_fits();
      bit [15:0] unloaded;
      bit        in_prog;
      unloaded = remaining;
      in_prog  = op == OP_PROGRAM && phase != PH_IDLE && phase <= PH_DATA;
      if (phase == PH_DATA && !byte_start() && unloaded != 0) unloaded--;
      return in_prog && !held_ok && unloaded != 0;
    endfunction

    function bit shifting();
      return phase == PH_WREN || (phase >= PH_CMD && phase <= PH_DATA) ||
             phase == PH_POLL_CMD || phase == PH_POLL_READ;
    endfunction

    function void drop_select();
      cs_active = 1'b0;
      sclk      = 1'b0;
      mosi      = 1'b0;
    endfunction

    function void end_of_byte(inout res_item_t r);
      case (phase)
        PH_WREN: phase = PH_WREN_END;
        PH_CMD: begin
          if (op == OP_READ_ID) begin
            phase     = PH_DATA;
            remaining = IdBytes;
            id_acc    = '0;
            tx_byte   = '0;
          end else begin
            phase   = PH_A2;
            tx_byte = addr[23:16];
          end
        end
        PH_A2: begin
          phase   = PH_A1;
          tx_byte = addr[15:8];
        end
        PH_A1: begin
          phase   = PH_A0;
          tx_byte = addr[7:0];
        end
        PH_A0: begin
          tx_byte = '0;
          phase   = (remaining == 0) ? PH_CMD_END : PH_DATA;
        end
        PH_DATA: begin
          if (op == OP_READ_ID) begin
            id_acc = {id_acc[15:0], rx_byte};
          end else if (op == OP_READ) begin
            r.data_out  = {16'd0, rx_byte};
            r.data_kind = KIND_BYTE;
          end
          remaining--;
          if (remaining == 0) begin
            if (op == OP_READ_ID) begin
              r.data_out  = id_acc;
              r.data_kind = KIND_ID;
            end
            phase = PH_CMD_END;
          end
        end
        PH_POLL_CMD: begin
          phase   = PH_POLL_READ;
          tx_byte = '0;
        end
        default: begin
          if (!rx_byte[StatusBusyBit]) phase = PH_DONE_END;
        end
      endcase
    endfunction

    function void half_tick(bit miso, inout res_item_t r);
      if (shifting()) begin
        if (!high_half) begin
          if (byte_start()) begin
            // No data byte held yet: the clock stays low and nothing moves.
            if (!held_ok) begin
              sclk = 1'b0;
              stall_ticks++;
              return;
            end
            tx_byte = held_byte;
            held_ok = 1'b0;
          end
          cs_active = 1'b1;
          sclk      = 1'b0;
          mosi      = tx_byte[bit_idx];
          high_half = 1'b1;
        end else begin
          sclk      = 1'b1;
          rx_byte   = {rx_byte[6:0], miso};
          high_half = 1'b0;
          if (bit_idx != 0) begin
            bit_idx--;
          end else begin
            bit_idx = 3'd7;
            end_of_byte(r);
          end
        end
      end else begin
        case (phase)
          PH_WREN_END: begin
            drop_select();
            phase   = PH_CMD;
            tx_byte = (op == OP_ERASE) ? CmdSectorErase : CmdPageProgram;
          end
          PH_CMD_END: begin
            drop_select();
            if (op == OP_ERASE || op == OP_PROGRAM) begin
              phase   = PH_POLL_CMD;
              tx_byte = CmdReadStatus;
            end else begin
              phase      = PH_IDLE;
              r.finished = 1'b1;
            end
          end
          PH_DONE_END: begin
            drop_select();
            phase      = PH_IDLE;
            r.finished = 1'b1;
          end
          default: ;
        endcase
      end
    endfunction

    function void note_request(req_item_t q);
      res_item_t r;
      r = '0;
      case (q.mode)
        MODE_START: begin
          if (busy()) begin
            r.status = STAT_BUSY;
            busy_starts++;
          end else begin
            op        = op_e'(q.operation);
            addr      = q.address;
            held_ok   = 1'b0;
            bit_idx   = 3'd7;
            high_half = 1'b0;
            if (op == OP_PROGRAM) begin
              remaining = (q.byte_count > PageBytes) ? 16'(PageBytes) : q.byte_count;
            end
            else if (op == OP_READ) remaining = q.byte_count;
            else remaining = '0;
            if (op == OP_READ_ID) begin
              phase   = PH_CMD;
              tx_byte = CmdReadId;
            end else if (op == OP_READ) begin
              phase   = PH_CMD;
              tx_byte = CmdReadData;
            end else begin
              phase   = PH_WREN;
              tx_byte = CmdWriteEnable;
            end
          end
        end
        MODE_SUPPLY: begin
          if (byte_fits()) begin
            held_byte = q.write_byte;
            held_ok   = 1'b1;
          end else begin
            r.status = STAT_NO_SUPPLY;
            refused_bytes++;
          end
        end
        MODE_TICK: half_tick(q.miso_bit, r);
        default: ;
      endcase
      r.chip_select_n = !cs_active;
      r.serial_clock  = sclk;
      r.serial_out    = mosi;
      r.need_byte     = wants_byte();
      r.busy_res      = busy();
      if (r.finished) ops_done++;
      if (r.data_kind == KIND_BYTE) bytes_read++;
      if (r.data_kind == KIND_ID) ids_read++;
      expected_pins.push_back(r);
    endfunction

    function void field_diff(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (expected_pins.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %0h", $time, got);
        return;
      end
      want = expected_pins.pop_front();
      checked++;
      field_diff("chip_select_n", want.chip_select_n, got.chip_select_n);
      field_diff("serial_clock", want.serial_clock, got.serial_clock);
      field_diff("serial_out", want.serial_out, got.serial_out);
      field_diff("data_out", want.data_out, got.data_out);
      field_diff("data_kind", want.data_kind, got.data_kind);
      field_diff("need_byte", want.need_byte, got.need_byte);
      field_diff("busy_res", want.busy_res, got.busy_res);
      field_diff("finished", want.finished, got.finished);
      field_diff("status", want.status, got.status);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  spi_nor_req_if req_if ();
  spi_nor_res_if res_if ();

  pin_scoreboard sb = new();

  int unsigned requests_sent;
  int unsigned burst_left;

  spi_nor_flash_command_sequencer #(
    .PAGE_BYTES(PageBytes)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) sb.check_result(res_if.item);
  end

  // Result side: random stalls, plus one long hold-off so the request side
  // backs up behind the result register.
  initial begin
    int unsigned left;
    bit          level;
    bit          held_off;
    left     = 0;
    level    = 1'b0;
    held_off = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        if (!held_off && sb.checked >= 300) begin
          held_off = 1'b1;
          level    = 1'b0;
          left     = HoldOffCycles;
        end else if ($urandom_range(0, 99) < 60) begin
          level = 1'b1;
          left  = $urandom_range(1, 40);
        end else begin
          level = 1'b0;
          left  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
      end
      left--;
      res_if.ready <= level;
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (res_if.valid === 1'b1 && res_if.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("spi_nor_flash_command_sequencer regression: fail");
    $finish;
  end

  function automatic req_item_t random_request(input logic [1:0] mode);
    req_item_t q;
    q.mode       = mode;
    q.operation  = 2'($urandom_range(0, 3));
    q.address    = 24'($urandom);
    q.byte_count = 16'($urandom);
    q.write_byte = 8'($urandom);
    q.miso_bit   = 1'($urandom);
    return q;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic send(input req_item_t q);
    int unsigned gap;
    req_if.item  <= q;
    req_if.valid <= 1'b1;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(q);
    requests_sent++;
    gap = sender_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Starts one operation and ticks it to completion. Noise requests (starts
  // while busy, stray data bytes, the reserved mode) are mixed in, and the
  // status read can be held busy for a number of ticks.
  task automatic run_operation(input op_e op, input logic [23:0] addr,
                               input logic [15:0] count, input int unsigned noise_pct,
                               input int unsigned wip_ticks);
    req_item_t   q;
    int unsigned pick;
    q            = random_request(MODE_START);
    q.operation  = op;
    q.address    = addr;
    q.byte_count = count;
    send(q);
    while (sb.busy()) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        pick = $urandom_range(0, 2);
        if (pick == 0) q = random_request(MODE_START);
        else if (pick == 1) q = random_request(MODE_SUPPLY);
        else q = random_request(ModeReserved);
      end else if (sb.byte_fits() &&
                   (sb.wants_byte() ? $urandom_range(0, 3) != 0 : $urandom_range(0, 7) == 0)) begin
        q = random_request(MODE_SUPPLY);
      end else begin
        q = random_request(MODE_TICK);
        if (sb.in_status_read() && wip_ticks != 0) begin
          q.miso_bit = 1'b1;
          wip_ticks--;
        end
      end
      send(q);
    end
  endtask

  initial begin
    op_e         op;
    logic [15:0] count;
    rst_ni        <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.item   <= '0;
    requests_sent = 0;
    burst_left    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Requests that do nothing while idle.
    send(random_request(MODE_TICK));
    send(random_request(ModeReserved));
    send(random_request(MODE_SUPPLY));

    run_operation(OP_READ_ID, 24'hFFFFFF, 16'hFFFF, 0, 0);
    run_operation(OP_READ, 24'hFFFFFF, 16'd0, 0, 0);
    run_operation(OP_READ, 24'h000000, 16'd3, 5, 0);
    run_operation(OP_ERASE, 24'h000000, 16'hFFFF, 0, 40);
    run_operation(OP_PROGRAM, 24'hFFFFFF, 16'd0, 0, 0);
    run_operation(OP_PROGRAM, 24'h5AA55A, 16'd4, 10, 20);

    while (requests_sent < TargetRequests) begin
      op    = op_e'($urandom_range(0, 3));
      count = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom_range(5, 24));
      run_operation(op, 24'($urandom), count, $urandom_range(0, 12),
                    $urandom_range(0, 1) ? $urandom_range(0, 40) : 0);
    end

    req_if.valid <= 1'b0;
    while (sb.expected_pins.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d requests, %0d results checked: %0d operations finished, %0d ids, %0d read bytes",
             requests_sent, sb.checked, sb.ops_done, sb.ids_read, sb.bytes_read);
    $display("%0d starts while busy, %0d data bytes refused, %0d ticks stalled for data",
             sb.busy_starts, sb.refused_bytes, sb.stall_ticks);
    if (sb.errors == 0) begin
      $display("spi_nor_flash_command_sequencer regression: pass");
    end else begin
      $display("spi_nor_flash_command_sequencer regression: fail");
    end
    $finish;
  end

endmodule
